@@ sv/vmg_pkg.sv @@
`default_nettype none
package vmg_pkg;

	// histogram geometry
	localparam int HIST_BINS = 1024;
	localparam int HIST_AW   = 10;

	// port widths
	localparam int S_DATA_W   = 80;
	localparam int S_USER_W   = 2;
	localparam int M_DATA_W   = 88;
	localparam int M_USER_W   = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_POPULATION = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_COUNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NOISE      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 3'd4;

	// operation codes
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_STEP  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// ln(2) in Q0.32
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;

	// bit-serial divider
	localparam int DIV_W     = 50;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	// log2 squaring iterations
	localparam int LOG_ITERS = 16;
	localparam int LCNT_W    = $clog2(LOG_ITERS);

	typedef enum logic [4:0] {
		ST_CLR,
		ST_IDLE,
		ST_RD0,
		ST_RD1,
		ST_SQ_N,
		ST_CUBE,
		ST_NOISE,
		ST_GAIN,
		ST_GAIN_D,
		ST_DIFF_N,
		ST_CNT_N,
		ST_SUM_C,
		ST_SUMS,
		ST_PROD_DN,
		ST_PROD_UP,
		ST_CHK,
		ST_DIV,
		ST_TRAP,
		ST_NORM,
		ST_SQR,
		ST_LN,
		ST_TDIV,
		ST_HRD,
		ST_HWR,
		ST_C0,
		ST_C1,
		ST_C2,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		DV_DN,
		DV_UP,
		DV_T
	} div_id_t;

endpackage
`default_nettype wire

@@ sv/voter_model_gillespie_step_top.sv @@
`default_nettype none
// Start: clears the histogram, one entry per cycle, then returns a result.
// Read: returns one histogram bin. Step: its time is set by the bit-serial divider
// (three quotients, one after another), the normalize and the log2 squaring loop;
// a negative rate ends the step at the rate check, a trapped step after the rate quotients.
// A new transaction can be taken in the cycle after a result is registered, while that result waits to drain.
// Reset is asynchronous; afterwards a clearing pass over all HIST_BINS entries runs.
module voter_model_gillespie_step_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// rand_time[31:0], rand_choice[63:32], bin_index[73:64], zero pad
	input  logic [vmg_pkg::S_DATA_W-1:0]    s_tdata,
	// op[1:0]
	input  logic [vmg_pkg::S_USER_W-1:0]    s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// copier_count[9:0], bin_value[41:10], sample_total[81:42], zero pad
	output logic [vmg_pkg::M_DATA_W-1:0]    m_tdata,
	// trapped[0], rate_error[1]
	output logic [vmg_pkg::M_USER_W-1:0]    m_tuser,
	input  logic                            cfg_we,
	input  logic [vmg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [vmg_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import vmg_pkg::*;

	// configuration
	logic [9:0]         pop_q;
	logic [9:0]         init_q;
	logic [15:0]        noise_q;
	logic signed [15:0] gain_q;
	logic [15:0]        thr_q;

	// control and model state
	state_t                state_q, state_d;
	logic [HIST_AW-1:0]    clr_q;
	logic                  from_start_q;
	logic [9:0]            count_q;
	logic [15:0]           frac_q;
	logic [39:0]           total_q;
	logic                  m_tvalid_q;
	logic [DIV_CNT_W-1:0]  div_cnt_q;
	logic [LCNT_W-1:0]     lcnt_q;

	// captured transaction
	logic [31:0] rt_q;
	logic [31:0] rc_q;
	logic [9:0]  bi_q;

	// rate datapath
	logic [19:0]        sq_q;
	logic [29:0]        cub_q;
	logic [35:0]        an2_q;
	logic signed [26:0] gn_q;
	logic signed [37:0] gnd_q;
	logic signed [21:0] dnp_q;
	logic [19:0]        nnp_q;
	logic signed [40:0] c_q;
	logic signed [40:0] s1_q;
	logic signed [40:0] s2_q;
	logic signed [51:0] dn_q;
	logic signed [51:0] up_q;

	// divider
	logic [DIV_W-1:0] dq_q;
	logic [DIV_W-1:0] dd_q;
	logic [DIV_W-1:0] dr_q;
	div_id_t          div_id_q;
	logic [DIV_W:0]   div_rn;
	logic             div_ge;
	logic [DIV_W-1:0] div_qn;
	logic             div_last;

	// rates, log and time
	logic [DIV_W-1:0] wdn_q;
	logic [DIV_W-1:0] wup_q;
	logic [DIV_W-1:0] wall_q;
	logic [31:0]      lm_q;
	logic [4:0]       lp_q;
	logic [15:0]      lf_q;
	logic [21:0]      nlr_q;
	logic [37:0]      t_q;
	logic [22:0]      whole_q;
	logic [15:0]      nfrac_q;
	logic [63:0]      plo_q;
	logic [49:0]      phm_q;

	// result
	logic        trap_q;
	logic        err_q;
	logic [31:0] bin_q;
	logic [9:0]  o_count_q;
	logic        o_trap_q;
	logic        o_err_q;
	logic [31:0] o_bin_q;
	logic [39:0] o_total_q;

	// combinational helpers
	logic [9:0]         pop_eff;
	logic signed [10:0] n_s;
	logic signed [10:0] pe_s;
	logic signed [10:0] d_s;
	logic               accept;
	logic               out_free;
	logic               trap_hit;
	logic               clr_last;
	logic [63:0]        sqr_p;
	logic [32:0]        sqr_hi;
	logic [21:0]        nl2;
	logic [53:0]        ln_p;
	logic [38:0]        acc;
	logic [32:0]        bin_sum;
	logic [31:0]        bin_sat;
	logic [40:0]        tot_sum;
	logic [50:0]        phi;
	logic               go_up;
	logic               cnt_in_range;
	logic               bi_in_range;

	// histogram memory
	logic               ram_we;
	logic [HIST_AW-1:0] ram_waddr;
	logic [31:0]        ram_wdata;
	logic [HIST_AW-1:0] ram_raddr;
	logic [31:0]        ram_rdata;

	vmg_ram #(.WIDTH(32), .DEPTH(HIST_BINS)) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign pop_eff  = (pop_q < 10'd2) ? 10'd2 : pop_q;
	assign n_s      = $signed({1'b0, count_q});
	assign pe_s     = $signed({1'b0, pop_eff});
	assign d_s      = pe_s - n_s;
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign clr_last = (clr_q == HIST_AW'(HIST_BINS - 1));
	// both rates below threshold, or both zero
	assign trap_hit = (wdn_q < DIV_W'(thr_q) && wup_q < DIV_W'(thr_q))
		|| (wdn_q == '0 && wup_q == '0);

	assign cnt_in_range = (32'(count_q) < HIST_BINS);
	assign bi_in_range  = (32'(bi_q) < HIST_BINS);

	// one restoring divider step
	assign div_rn   = {dr_q, dq_q[DIV_W-1]};
	assign div_ge   = (div_rn >= {1'b0, dd_q});
	assign div_qn   = {dq_q[DIV_W-2:0], div_ge};
	assign div_last = (div_cnt_q == DIV_CNT_W'(DIV_W - 1));

	// log2 squaring step and ln scaling
	assign sqr_p  = 64'(lm_q) * 64'(lm_q);
	assign sqr_hi = sqr_p[63:31];
	assign nl2    = {6'd32 - {1'b0, lp_q}, 16'b0} - {6'b0, lf_q};
	assign ln_p   = 54'(nl2) * 54'(LN2_Q32);

	// time accumulation and saturating updates
	assign acc     = {1'b0, t_q} + 39'(frac_q);
	assign bin_sum = {1'b0, ram_rdata} + 33'(whole_q);
	assign bin_sat = bin_sum[32] ? '1 : bin_sum[31:0];
	assign tot_sum = {1'b0, total_q} + 41'(whole_q);

	// transition choice
	assign phi   = 51'(phm_q) + 51'(plo_q[63:32]);
	assign go_up = (phi < 51'(wup_q));

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop_q   <= 10'd1000;
			init_q  <= 10'd500;
			noise_q <= 16'd66;
			gain_q  <= '0;
			thr_q   <= 16'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_POPULATION: pop_q   <= cfg_data[9:0];
				CFG_INIT_COUNT: init_q  <= cfg_data[9:0];
				CFG_NOISE:      noise_q <= cfg_data;
				CFG_GAIN:       gain_q  <= $signed(cfg_data);
				CFG_THRESHOLD:  thr_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// next state, memory port and input ready
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = HIST_AW'(count_q);
		ram_wdata = '0;
		ram_raddr = HIST_AW'(count_q);
		unique case (state_q)
			ST_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				if (clr_last) state_d = from_start_q ? ST_FIN : ST_IDLE;
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					unique case (s_tuser)
						OP_START: state_d = ST_CLR;
						OP_STEP:  state_d = ST_SQ_N;
						OP_READ:  state_d = ST_RD0;
						default:  state_d = ST_FIN;
					endcase
				end
			end
			ST_RD0: begin
				ram_raddr = HIST_AW'(bi_q);
				state_d   = ST_RD1;
			end
			ST_RD1:     state_d = ST_FIN;
			ST_SQ_N:    state_d = ST_CUBE;
			ST_CUBE:    state_d = ST_NOISE;
			ST_NOISE:   state_d = ST_GAIN;
			ST_GAIN:    state_d = ST_GAIN_D;
			ST_GAIN_D:  state_d = ST_DIFF_N;
			ST_DIFF_N:  state_d = ST_CNT_N;
			ST_CNT_N:   state_d = ST_SUM_C;
			ST_SUM_C:   state_d = ST_SUMS;
			ST_SUMS:    state_d = ST_PROD_DN;
			ST_PROD_DN: state_d = ST_PROD_UP;
			ST_PROD_UP: state_d = ST_CHK;
			ST_CHK:     state_d = (dn_q[51] || up_q[51]) ? ST_FIN : ST_DIV;
			ST_DIV: begin
				if (div_last) begin
					unique case (div_id_q)
						DV_DN:   state_d = ST_DIV;
						DV_UP:   state_d = ST_TRAP;
						DV_T:    state_d = ST_HRD;
						default: state_d = ST_FIN;
					endcase
				end
			end
			ST_TRAP: state_d = trap_hit ? ST_FIN : ST_NORM;
			ST_NORM: if (lm_q[31] || lp_q == '0) state_d = ST_SQR;
			ST_SQR:  if (lcnt_q == LCNT_W'(LOG_ITERS - 1)) state_d = ST_LN;
			ST_LN:   state_d = ST_TDIV;
			ST_TDIV: state_d = ST_DIV;
			ST_HRD:  state_d = ST_HWR;
			ST_HWR: begin
				ram_we    = cnt_in_range;
				ram_wdata = bin_sat;
				state_d   = ST_C0;
			end
			ST_C0: state_d = ST_C1;
			ST_C1: state_d = ST_C2;
			ST_C2: state_d = ST_FIN;
			ST_FIN: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// control state, counters and model state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			clr_q        <= '0;
			from_start_q <= 1'b0;
			count_q      <= '0;
			frac_q       <= '0;
			total_q      <= '0;
			m_tvalid_q   <= 1'b0;
			div_cnt_q    <= '0;
			lcnt_q       <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLR) clr_q <= clr_last ? '0 : clr_q + 1'b1;
			if (accept) begin
				from_start_q <= (s_tuser == OP_START);
				if (s_tuser == OP_START) begin
					count_q <= init_q;
					frac_q  <= '0;
					total_q <= '0;
				end
			end
			div_cnt_q <= (state_q == ST_DIV && !div_last) ? div_cnt_q + 1'b1 : '0;
			lcnt_q    <= (state_q == ST_SQR) ? lcnt_q + 1'b1 : '0;
			if (state_q == ST_HWR) begin
				frac_q  <= nfrac_q;
				total_q <= tot_sum[40] ? '1 : tot_sum[39:0];
			end
			if (state_q == ST_C2) begin
				if (go_up) begin
					if (count_q != 10'd1023) count_q <= count_q + 1'b1;
				end else begin
					if (count_q != 10'd0) count_q <= count_q - 1'b1;
				end
			end
			if (state_q == ST_FIN && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			rt_q   <= s_tdata[31:0];
			rc_q   <= s_tdata[63:32];
			bi_q   <= s_tdata[73:64];
			trap_q <= 1'b0;
			err_q  <= 1'b0;
			bin_q  <= '0;
		end
		case (state_q)
			ST_RD1:     bin_q <= bi_in_range ? ram_rdata : '0;
			ST_SQ_N:    sq_q  <= 20'(pop_eff) * 20'(pop_eff);
			ST_CUBE:    cub_q <= 30'(sq_q) * 30'(pop_eff);
			ST_NOISE:   an2_q <= 36'(noise_q) * 36'(sq_q);
			ST_GAIN:    gn_q  <= 27'(gain_q) * 27'(n_s);
			ST_GAIN_D:  gnd_q <= 38'(gn_q) * 38'(d_s);
			ST_DIFF_N:  dnp_q <= 22'(d_s) * 22'(pe_s);
			ST_CNT_N:   nnp_q <= 20'(count_q) * 20'(pop_eff);
			ST_SUM_C:   c_q   <= $signed({5'b0, an2_q}) + (41'(gnd_q) <<< 3);
			ST_SUMS: begin
				s1_q <= c_q + (41'(dnp_q) <<< 16);
				s2_q <= c_q + $signed({5'b0, nnp_q, 16'b0});
			end
			ST_PROD_DN: dn_q <= 52'(s1_q) * 52'(n_s);
			ST_PROD_UP: up_q <= 52'(s2_q) * 52'(d_s);
			ST_CHK: begin
				err_q    <= dn_q[51] || up_q[51];
				dq_q     <= dn_q[DIV_W-1:0];
				dd_q     <= DIV_W'(cub_q);
				dr_q     <= '0;
				div_id_q <= DV_DN;
			end
			ST_DIV: begin
				if (div_last && div_id_q == DV_DN) begin
					// down rate done, restart on the up rate with the same divisor
					wdn_q    <= div_qn;
					dq_q     <= up_q[DIV_W-1:0];
					dr_q     <= '0;
					div_id_q <= DV_UP;
				end else begin
					dq_q <= div_qn;
					dr_q <= div_ge ? DIV_W'(div_rn - {1'b0, dd_q}) : div_rn[DIV_W-1:0];
					if (div_last) begin
						case (div_id_q)
							DV_UP:   wup_q <= div_qn;
							default: t_q   <= div_qn[37:0];
						endcase
					end
				end
			end
			ST_TRAP: begin
				trap_q <= trap_hit;
				wall_q <= wdn_q + wup_q;
				lm_q   <= (rt_q == '0) ? 32'd1 : rt_q;
				lp_q   <= 5'd31;
				lf_q   <= '0;
			end
			ST_NORM: begin
				if (!lm_q[31] && lp_q != '0) begin
					lm_q <= {lm_q[30:0], 1'b0};
					lp_q <= lp_q - 1'b1;
				end
			end
			ST_SQR: begin
				lm_q <= sqr_hi[32] ? sqr_hi[32:1] : sqr_hi[31:0];
				lf_q <= {lf_q[14:0], sqr_hi[32]};
			end
			ST_LN: nlr_q <= ln_p[53:32];
			ST_TDIV: begin
				dq_q     <= DIV_W'({nlr_q, 16'b0});
				dd_q     <= wall_q;
				dr_q     <= '0;
				div_id_q <= DV_T;
			end
			ST_HRD: begin
				whole_q <= acc[38:16];
				nfrac_q <= acc[15:0];
			end
			ST_C0: plo_q <= 64'(wall_q[31:0]) * 64'(rc_q);
			ST_C1: phm_q <= 50'(wall_q[DIV_W-1:32]) * 50'(rc_q);
			ST_FIN: begin
				if (out_free) begin
					o_count_q <= count_q;
					o_trap_q  <= trap_q;
					o_err_q   <= err_q;
					o_bin_q   <= bin_q;
					o_total_q <= total_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b0, o_total_q, o_bin_q, o_count_q};
	assign m_tuser  = {o_err_q, o_trap_q};

	// no transaction is taken during a clearing pass
	a_clr_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR) |-> !s_tready)
		else $error("input accepted during clearing pass");

	// histogram is written only by the clearing pass or the bin update
	a_ram_we_src: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_CLR || state_q == ST_HWR))
		else $error("unexpected histogram write");

	// an accepted transaction always leaves idle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE))
		else $error("block stayed idle after accept");

	// trapped and rate error never reported together
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("trapped and rate error both set");

	// third quotient only after the rate quotients gave a nonzero total
	a_tdiv_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TDIV) |-> (wall_q != '0))
		else $error("time divide by zero rate");

endmodule
`default_nettype wire

@@ sv/vmg_ram.sv @@
`default_nettype none
module vmg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire
